@@ sv/jpt_pkg.sv @@
// ----------------------------------------------------------------------------
// jpt_pkg
// Shared types and constants for the JSON pointer tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package jpt_pkg;

  localparam int INDEX_BITS_DEF = 32;  // default accumulator width
  localparam int IDX_OUT_W      = 32;  // width of the reported index value
  localparam int MAX_RES        = 3;   // results one input beat can cause
  localparam int Q_DEPTH        = 2;   // entries between front and back
  localparam int DATA_OUT_W     = 48;  // out_tdata width, whole bytes

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_SEGEND  = 2'd1,
    KIND_ROOT    = 2'd2,
    KIND_INVALID = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                  kind;
    logic [7:0]             data_byte;
    logic                   is_index;
    logic [IDX_OUT_W-1:0]   index_value;
    logic                   index_overflow;
    logic                   last_ptr;
    logic                   last_step;
  } res_t;

  // one input beat's worth of results; rec[0] goes out first
  typedef struct packed {
    logic [1:0]             count;
    res_t [MAX_RES-1:0]     rec;
  } entry_t;

endpackage

`default_nettype wire

@@ sv/jpt_front.sv @@
// ----------------------------------------------------------------------------
// jpt_front
// Accepts pointer bytes, tracks segment/escape state and builds the list
// of results each beat causes.
// ----------------------------------------------------------------------------
`default_nettype none

module jpt_front #(
  parameter int INDEX_BITS = jpt_pkg::INDEX_BITS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire logic [7:0]      in_tdata,   // [7:0] char_byte
  input  wire logic            in_tuser,   // [0] has_char
  input  wire logic            in_tlast,   // end_of_pointer
  output logic                 q_push,
  output jpt_pkg::entry_t      q_entry,
  input  wire logic            q_ready
);

  localparam int OW = jpt_pkg::IDX_OUT_W;
  localparam int NR = jpt_pkg::MAX_RES;

  logic                  started_r, started_nxt;
  logic                  err_skip_r, err_skip_nxt;
  logic                  tilde_r, tilde_nxt;
  logic                  nonempty_r, nonempty_nxt;
  logic                  all_dig_r, all_dig_nxt;
  logic [INDEX_BITS-1:0] acc_r, acc_nxt;
  logic                  acc_ovf_r, acc_ovf_nxt;

  logic                  accept;
  logic [INDEX_BITS+3:0] acc10;
  logic                  acc_over;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= jpt_pkg::CH_ZERO) && (b <= jpt_pkg::CH_NINE);
  endfunction

  assign in_tready = q_ready;
  assign accept    = in_tvalid && in_tready;

  // only a plain digit taken straight from the input can extend the index
  assign acc10 = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0}
               + {{INDEX_BITS{1'b0}}, in_tdata[3:0]};
  assign acc_over = |acc10[INDEX_BITS+3:INDEX_BITS];

  always_comb begin
    jpt_pkg::kind_t        act_kind [NR];
    logic [7:0]            act_byte [NR];
    logic [1:0]            n_act;
    logic                  closes;
    logic                  w_started, w_err, w_tilde, w_nonempty, w_alldig, w_ovf;
    logic [INDEX_BITS-1:0] w_acc;
    logic                  idx;
    jpt_pkg::entry_t       ent;

    for (int i = 0; i < NR; i++) begin
      act_kind[i] = jpt_pkg::KIND_BYTE;
      act_byte[i] = '0;
    end
    n_act      = 2'd0;
    closes     = 1'b0;
    w_started  = started_r;
    w_err      = err_skip_r;
    w_tilde    = tilde_r;
    w_nonempty = nonempty_r;
    w_alldig   = all_dig_r;
    w_acc      = acc_r;
    w_ovf      = acc_ovf_r;
    idx        = 1'b0;
    ent        = '0;

    // build the action list for this beat
    if (err_skip_r) begin
      if (in_tlast) w_err = 1'b0;
    end else if (!started_r) begin
      if (!in_tuser) begin
        act_kind[0] = jpt_pkg::KIND_ROOT;
        n_act       = 2'd1;
        closes      = 1'b1;
      end else if (in_tdata != jpt_pkg::CH_SLASH) begin
        act_kind[0] = jpt_pkg::KIND_INVALID;
        n_act       = 2'd1;
        if (in_tlast) closes = 1'b1;
        else w_err = 1'b1;
      end else begin
        w_started = 1'b1;
        if (in_tlast) begin
          act_kind[0] = jpt_pkg::KIND_SEGEND;
          n_act       = 2'd1;
          closes      = 1'b1;
        end
      end
    end else begin
      if (in_tuser) begin
        if (w_tilde) begin
          w_tilde = 1'b0;
          act_kind[n_act] = jpt_pkg::KIND_BYTE;
          act_byte[n_act] = (in_tdata == jpt_pkg::CH_ONE) ? jpt_pkg::CH_SLASH
                                                          : jpt_pkg::CH_TILDE;
          n_act = n_act + 2'd1;
        end
        // a tilde not followed by 0 or 1 leaves the byte to be read plainly
        if (!(tilde_r && (in_tdata == jpt_pkg::CH_ZERO || in_tdata == jpt_pkg::CH_ONE))) begin
          if (in_tdata == jpt_pkg::CH_SLASH) begin
            act_kind[n_act] = jpt_pkg::KIND_SEGEND;
            n_act = n_act + 2'd1;
          end else if (in_tdata == jpt_pkg::CH_TILDE) begin
            w_tilde = 1'b1;
          end else begin
            act_kind[n_act] = jpt_pkg::KIND_BYTE;
            act_byte[n_act] = in_tdata;
            n_act = n_act + 2'd1;
          end
        end
      end
      if (in_tlast) begin
        if (w_tilde) begin
          w_tilde = 1'b0;
          act_kind[n_act] = jpt_pkg::KIND_BYTE;
          act_byte[n_act] = jpt_pkg::CH_TILDE;
          n_act = n_act + 2'd1;
        end
        act_kind[n_act] = jpt_pkg::KIND_SEGEND;
        n_act  = n_act + 2'd1;
        closes = 1'b1;
      end
    end

    // carry out the actions in order
    for (int i = 0; i < NR; i++) begin
      if (i < int'(n_act)) begin
        ent.rec[i].kind = act_kind[i];
        unique case (act_kind[i])
          jpt_pkg::KIND_BYTE: begin
            ent.rec[i].data_byte = act_byte[i];
            w_nonempty = 1'b1;
            if (is_digit(act_byte[i])) begin
              if (w_alldig && !w_ovf) begin
                w_acc = acc_over ? '1 : acc10[INDEX_BITS-1:0];
                w_ovf = acc_over;
              end
            end else begin
              w_alldig = 1'b0;
            end
          end
          jpt_pkg::KIND_SEGEND: begin
            idx = w_nonempty && w_alldig;
            ent.rec[i].is_index       = idx;
            ent.rec[i].index_value    = idx ? OW'(w_acc) : '0;
            ent.rec[i].index_overflow = idx && w_ovf;
            w_nonempty = 1'b0;
            w_alldig   = 1'b1;
            w_acc      = '0;
            w_ovf      = 1'b0;
          end
          jpt_pkg::KIND_ROOT: begin
          end
          jpt_pkg::KIND_INVALID: begin
            ent.rec[i].last_ptr = 1'b1;
          end
        endcase
      end
    end

    if (n_act != 2'd0) begin
      ent.rec[n_act - 2'd1].last_step = 1'b1;
      if (closes) ent.rec[n_act - 2'd1].last_ptr = 1'b1;
    end
    ent.count = n_act;

    if (closes) begin
      w_started  = 1'b0;
      w_tilde    = 1'b0;
      w_nonempty = 1'b0;
      w_alldig   = 1'b1;
      w_acc      = '0;
      w_ovf      = 1'b0;
    end

    started_nxt  = w_started;
    err_skip_nxt = w_err;
    tilde_nxt    = w_tilde;
    nonempty_nxt = w_nonempty;
    all_dig_nxt  = w_alldig;
    acc_nxt      = w_acc;
    acc_ovf_nxt  = w_ovf;
    q_entry      = ent;
    q_push       = accept && (n_act != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r  <= 1'b0;
      err_skip_r <= 1'b0;
      tilde_r    <= 1'b0;
      nonempty_r <= 1'b0;
      all_dig_r  <= 1'b1;
      acc_r      <= '0;
      acc_ovf_r  <= 1'b0;
    end else if (accept) begin
      started_r  <= started_nxt;
      err_skip_r <= err_skip_nxt;
      tilde_r    <= tilde_nxt;
      nonempty_r <= nonempty_nxt;
      all_dig_r  <= all_dig_nxt;
      acc_r      <= acc_nxt;
      acc_ovf_r  <= acc_ovf_nxt;
    end
  end

  // the final record of a pushed entry always closes the beat
  a_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> q_entry.rec[q_entry.count - 2'd1].last_step)
    else $error("pushed entry lacks last_step on its final record");

  // never both inside a pointer and skipping a rejected one
  a_skip_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(started_r && err_skip_r))
    else $error("started and error skip both set");

endmodule

`default_nettype wire

@@ sv/jpt_queue.sv @@
// ----------------------------------------------------------------------------
// jpt_queue
// Short entry queue decoupling the classifier from the result serialiser.
// ----------------------------------------------------------------------------
`default_nettype none

module jpt_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire jpt_pkg::entry_t push_entry,
  output logic                 push_ready,
  input  wire logic            pop,
  output jpt_pkg::entry_t      head,
  output logic                 head_valid
);

  localparam int D     = jpt_pkg::Q_DEPTH;
  localparam int PTR_W = (D > 1) ? $clog2(D) : 1;
  localparam int CNT_W = $clog2(D + 1);

  jpt_pkg::entry_t   store_r [D];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign push_ready = (cnt_r != CNT_W'(D));
  assign head_valid = (cnt_r != '0);
  assign head       = store_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == PTR_W'(D - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == PTR_W'(D - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    if (do_push && !do_pop)      cnt_nxt = cnt_r + CNT_W'(1);
    else if (do_pop && !do_push) cnt_nxt = cnt_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) store_r[wr_ptr_r] <= push_entry;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(D))
    else $error("queue occupancy above depth");

endmodule

`default_nettype wire

@@ sv/jpt_back.sv @@
// ----------------------------------------------------------------------------
// jpt_back
// Walks the records of the head entry, one result beat per cycle while the
// receiver is ready, into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module jpt_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire jpt_pkg::entry_t head,
  input  wire logic            head_valid,
  output logic                 pop,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output jpt_pkg::res_t        out_rec
);

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    sub_r, sub_nxt;
  jpt_pkg::res_t rec_r;
  logic          load;
  logic          last_rec;

  assign out_tvalid = out_valid_r;
  assign out_rec    = rec_r;
  assign load       = head_valid && (!out_valid_r || out_tready);
  assign last_rec   = (sub_r == head.count - 2'd1);
  assign pop        = load && last_rec;

  always_comb begin
    out_valid_nxt = out_valid_r;
    sub_nxt       = sub_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      sub_nxt       = last_rec ? 2'd0 : sub_r + 2'd1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sub_r       <= 2'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sub_r       <= sub_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) rec_r <= head.rec[sub_r];
  end

  a_sub_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> (sub_r < head.count))
    else $error("record pointer beyond head entry");

  a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (out_valid_r && rec_r.last_step))
    else $error("entry retired without its last_step record");

endmodule

`default_nettype wire

@@ sv/json_pointer_tokenizer_core.sv @@
// ----------------------------------------------------------------------------
// json_pointer_tokenizer_core
// JSON pointer tokenizer: splits a pointer into unescaped key bytes and
// segment-end reports with array index decoding.
// ----------------------------------------------------------------------------
// Input stream: one pointer byte per beat on in_tdata, in_tuser flags a valid
// byte (low only for a zero-length pointer), in_tlast marks the final beat.
// Output stream: one result per beat; out_tuser is the result kind (key byte,
// segment end, root, invalid), out_tlast marks the final result of a pointer.
// A front stage classifies each beat and updates escape/index state,
// pushing that beat's results (zero to three) into a two-entry queue.
// A back stage drains the queue into an output register, one result per
// cycle while the receiver is ready; a beat's first result passes through
// the queue entry, then the output register. Throughput: one input beat per
// cycle while beats cause one result each and the receiver is ready; a beat
// causing several results holds the output register for each in turn.
// Beats causing no result skip the output but wait while the queue is full.
// When the receiver stalls, the output holds and the queue fills; in_tready
// falls once both queue entries are occupied.
// Reset (rst_n low, synchronous) empties the queue and the output and returns
// the tokenizer to the start of a pointer.
// ----------------------------------------------------------------------------
`default_nettype none

module json_pointer_tokenizer_core #(
  parameter int INDEX_BITS = jpt_pkg::INDEX_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [7:0]                   in_tdata,   // [7:0] char_byte
  input  wire logic                         in_tuser,   // [0] has_char
  input  wire logic                         in_tlast,   // end_of_pointer
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  // [7:0] out_byte, [8] is_index, [40:9] index_value, [41] index_overflow,
  // [42] last_of_step, [47:43] zero
  output logic [jpt_pkg::DATA_OUT_W-1:0]    out_tdata,
  output logic [1:0]                        out_tuser,  // [1:0] kind
  output logic                              out_tlast   // last_of_pointer
);

  localparam int OW = jpt_pkg::IDX_OUT_W;
  localparam int PAD_W = jpt_pkg::DATA_OUT_W - (8 + 1 + OW + 1 + 1);

  logic            q_push, q_ready, q_pop, q_valid;
  jpt_pkg::entry_t q_in, q_head;
  jpt_pkg::res_t   rec;

  jpt_front #(
    .INDEX_BITS (INDEX_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_push    (q_push),
    .q_entry   (q_in),
    .q_ready   (q_ready)
  );

  jpt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .push_ready (q_ready),
    .pop        (q_pop),
    .head       (q_head),
    .head_valid (q_valid)
  );

  jpt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .head_valid (q_valid),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_rec    (rec)
  );

  assign out_tdata = {{PAD_W{1'b0}}, rec.last_step, rec.index_overflow,
                      rec.index_value, rec.is_index, rec.data_byte};
  assign out_tuser = rec.kind;
  assign out_tlast = rec.last_ptr;

endmodule

`default_nettype wire
